// ===== rtl/utf8_stream_sanitizer_macros.svh =====
// Assertion macros shared by the UTF-8 sanitizer checker.
// Include guard only; no other conditional text.
`ifndef UTF8_STREAM_SANITIZER_MACROS_SVH
`define UTF8_STREAM_SANITIZER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define U8S_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define U8S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked across reset as well.
`define U8S_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/utf8s_pkg.sv =====
// Package for the UTF-8 stream sanitizer: byte classes, DFA state codes,
// and the validation transition table. No dependencies.
`timescale 1ns / 1ps

package utf8s_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATE_W    = 4;
    localparam int unsigned HELD_DEPTH = 3;
    localparam int unsigned OBUF_DEPTH = 4;

    localparam logic [BYTE_W-1:0] REPL_CHAR = 8'h3F;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    // DFA state codes
    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

    typedef logic [3:0] t_btype;

    // Byte classes
    localparam t_btype BT_ASCII = 4'd0;   // 00-7F
    localparam t_btype BT_CONT1 = 4'd1;   // 80-8F
    localparam t_btype BT_LEAD2 = 4'd2;   // C2-DF
    localparam t_btype BT_LEAD3 = 4'd3;   // E1-EC, EE-EF
    localparam t_btype BT_ED    = 4'd4;   // ED
    localparam t_btype BT_F4    = 4'd5;   // F4
    localparam t_btype BT_LEAD4 = 4'd6;   // F1-F3
    localparam t_btype BT_CONT3 = 4'd7;   // A0-BF
    localparam t_btype BT_BAD   = 4'd8;   // C0, C1, F5-FF
    localparam t_btype BT_CONT2 = 4'd9;   // 90-9F
    localparam t_btype BT_E0    = 4'd10;  // E0
    localparam t_btype BT_F0    = 4'd11;  // F0

    localparam logic [STATE_W-1:0] NEXT_STATE [0:8][0:15] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    function automatic t_btype byte_type(input logic [BYTE_W-1:0] b);
        t_btype t;
        if (b < 8'h80)       t = BT_ASCII;
        else if (b < 8'h90)  t = BT_CONT1;
        else if (b < 8'hA0)  t = BT_CONT2;
        else if (b < 8'hC0)  t = BT_CONT3;
        else if (b < 8'hC2)  t = BT_BAD;
        else if (b < 8'hE0)  t = BT_LEAD2;
        else if (b == 8'hE0) t = BT_E0;
        else if (b == 8'hED) t = BT_ED;
        else if (b < 8'hF0)  t = BT_LEAD3;
        else if (b == 8'hF0) t = BT_F0;
        else if (b < 8'hF4)  t = BT_LEAD4;
        else if (b == 8'hF4) t = BT_F4;
        else                 t = BT_BAD;
        return t;
    endfunction

    // States past the table are treated as reject.
    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] cur,
                                                      input t_btype ty);
        logic [STATE_W-1:0] ns;
        if (cur > ST_LAST) ns = ST_REJECT;
        else               ns = NEXT_STATE[cur][ty];
        return ns;
    endfunction

endpackage

// ===== rtl/utf8_stream_sanitizer.sv =====
// UTF-8 stream sanitizer top level: input register, DFA step, result buffer.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave channel: one raw byte per transfer on i_s_axis_tdata, i_s_axis_tlast
//   marks the final byte of a buffer. Master channel: one sanitized byte per
//   transfer on o_m_axis_tdata; o_m_axis_tuser flags an inserted '?', and
//   o_m_axis_tlast marks the final result caused by one input byte.
//   A byte yields zero results (held in a sequence, or a skipped continuation
//   after an error), one result, or up to four (a completed sequence plus the
//   bytes held for it). A tlast byte inside a sequence adds one '?'.
//   An accepted byte is registered in the input register, stepped through
//   the DFA, and its results are registered in the result buffer. Throughput:
//   one byte per cycle while each byte yields at most one result and the
//   master side is ready; a byte that yields n results occupies the result
//   buffer until all n drain, one result per cycle while the master is ready.
//   Stalls: while the master side stalls, the buffer holds its results and
//   one more byte waits in the input register; then o_s_axis_tready drops.
//   Reset (i_rst_n low, synchronous): the DFA returns to accept, held bytes
//   and the skip flag are dropped, and both registers empty. No clearing pass.
module utf8_stream_sanitizer
    import utf8s_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [BYTE_W-1:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic                i_s_axis_tlast,   // end_of_buffer
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [BYTE_W-1:0]   o_m_axis_tdata,   // [7:0] out_byte
    output logic                o_m_axis_tuser,   // [0] is_replacement
    output logic                o_m_axis_tlast    // last_of_run
);

    localparam int unsigned CNT_W  = $clog2(OBUF_DEPTH + 1);
    localparam int unsigned HCNT_W = $clog2(HELD_DEPTH + 1);

    // input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_eob;

    // sequence state
    logic [STATE_W-1:0]  r_dfa;
    logic [BYTE_W-1:0]   r_held [HELD_DEPTH];
    logic [HCNT_W-1:0]   r_hcnt;
    logic                r_skip;

    // result buffer, head at entry 0
    logic [BYTE_W-1:0]   r_ob_byte [OBUF_DEPTH];
    logic                r_ob_rep  [OBUF_DEPTH];
    logic [CNT_W-1:0]    r_ob_cnt;

    logic                w_in_fire;
    logic                w_out_fire;
    logic                w_proc_fire;
    logic                w_is_cont;
    logic                w_skip_byte;
    logic [STATE_W-1:0]  w_ns;
    logic [1:0]          w_hidx;
    logic [BYTE_W-1:0]   w_ext [OBUF_DEPTH];

    logic [BYTE_W-1:0]   n_ld_byte [OBUF_DEPTH];
    logic                n_ld_rep  [OBUF_DEPTH];
    logic [CNT_W-1:0]    n_ld_cnt;
    logic [STATE_W-1:0]  n_dfa;
    logic [HCNT_W-1:0]   n_hcnt;
    logic                n_skip;
    logic                n_hold_wr;

    assign w_out_fire  = o_m_axis_tvalid & i_m_axis_tready;
    assign w_proc_fire = r_in_valid &
                         ((r_ob_cnt == '0) ||
                          (r_ob_cnt == CNT_W'(1) && w_out_fire) ||
                          (n_ld_cnt == '0));
    assign o_s_axis_tready = ~r_in_valid | w_proc_fire;
    assign w_in_fire       = i_s_axis_tvalid & o_s_axis_tready;

    assign w_is_cont   = (r_in_byte & CONT_MASK) == CONT_TAG;
    assign w_skip_byte = r_skip & w_is_cont;
    assign w_ns        = next_state(r_dfa, byte_type(r_in_byte));
    // count 3 never stores; kept consistent with the index rule anyway
    assign w_hidx      = r_hcnt[0] ? 2'd1 : (r_hcnt[1] ? 2'd2 : 2'd0);

    always_comb begin
        for (int i = 0; i < OBUF_DEPTH; i++) begin
            w_ext[i] = (i < HELD_DEPTH) ? r_held[i] : r_in_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < OBUF_DEPTH; i++) begin
            n_ld_byte[i] = REPL_CHAR;
            n_ld_rep[i]  = 1'b1;
        end
        n_ld_cnt  = '0;
        n_dfa     = r_dfa;
        n_hcnt    = r_hcnt;
        n_skip    = r_skip;
        n_hold_wr = 1'b0;

        if (!w_skip_byte) begin
            n_skip = 1'b0;
            if (w_ns == ST_ACCEPT) begin
                // held bytes in order, then the current byte
                for (int i = 0; i < OBUF_DEPTH; i++) begin
                    n_ld_byte[i] = (CNT_W'(i) < CNT_W'(r_hcnt)) ? w_ext[i] : r_in_byte;
                    n_ld_rep[i]  = 1'b0;
                end
                n_ld_cnt = CNT_W'(r_hcnt) + CNT_W'(1);
                n_hcnt   = '0;
                n_dfa    = ST_ACCEPT;
            end else if (w_ns == ST_REJECT) begin
                n_ld_cnt = CNT_W'(1);
                n_hcnt   = '0;
                n_dfa    = ST_ACCEPT;
                n_skip   = 1'b1;
            end else begin
                n_hold_wr = 1'b1;
                n_hcnt    = r_hcnt + HCNT_W'(1);
                n_dfa     = w_ns;
            end
        end

        if (r_in_eob) begin
            // sequence cut short by the end of the buffer: one '?'
            if (n_dfa != ST_ACCEPT) begin
                n_ld_cnt = CNT_W'(1);
            end
            n_dfa  = ST_ACCEPT;
            n_hcnt = '0;
            n_skip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eob  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfa  <= ST_ACCEPT;
            r_hcnt <= '0;
            r_skip <= 1'b0;
        end else if (w_proc_fire) begin
            r_dfa  <= n_dfa;
            r_hcnt <= n_hcnt;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_fire && n_hold_wr) begin
            r_held[w_hidx] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else if (w_proc_fire && n_ld_cnt != '0) begin
            r_ob_cnt <= n_ld_cnt;
        end else if (w_out_fire) begin
            r_ob_cnt <= r_ob_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_fire && n_ld_cnt != '0) begin
            for (int i = 0; i < OBUF_DEPTH; i++) begin
                r_ob_byte[i] <= n_ld_byte[i];
                r_ob_rep[i]  <= n_ld_rep[i];
            end
        end else if (w_out_fire) begin
            for (int i = 0; i < OBUF_DEPTH - 1; i++) begin
                r_ob_byte[i] <= r_ob_byte[i+1];
                r_ob_rep[i]  <= r_ob_rep[i+1];
            end
        end
    end

    assign o_m_axis_tvalid = r_ob_cnt != '0;
    assign o_m_axis_tdata  = r_ob_byte[0];
    assign o_m_axis_tuser  = r_ob_rep[0];
    assign o_m_axis_tlast  = r_ob_cnt == CNT_W'(1);

endmodule

// ===== rtl/utf8s_checker.sv =====
// Port-level checker for the UTF-8 stream sanitizer, bound to the top level.
// Depends on utf8_stream_sanitizer_macros.svh.
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_macros.svh"

module utf8s_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  o_m_axis_tdata,
    input  logic        o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    // a replacement is always '?'
    `U8S_ASSERT_NOW(a_repl_char, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == 8'h3F, "replacement transfer is not '?'")

    // a replacement never shares a run with other results
    `U8S_ASSERT_NOW(a_repl_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast, "replacement transfer is not last of its run")

    // bytes that can never appear in valid UTF-8 never pass through
    `U8S_ASSERT_NOW(a_no_bad_byte, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata != 8'hC0 && o_m_axis_tdata != 8'hC1 && o_m_axis_tdata < 8'hF5, "invalid byte passed through")

    // a stalled result holds
    `U8S_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

    // reset empties the result buffer
    `U8S_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid right after reset")

endmodule

bind utf8_stream_sanitizer utf8s_checker u_utf8s_checker (.*);

// ===== tb/tb_utf8_stream_sanitizer.sv =====
// Self-checking testbench for utf8_stream_sanitizer: streams raw bytes in, predicts the
// sanitized byte stream in a local copy of the validation DFA and checks every output transfer.
// Depends on utf8s_pkg (byte class and state codes) and the RTL top level.
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;
    import utf8s_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       last_of_run;
    } t_san_out;

    localparam int unsigned HALF_PERIOD = 4;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned DRAIN_LIMIT = 50000;
    localparam int unsigned TAIL_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tuser;
    wire        m_tlast;

    // prediction state
    logic [3:0] dfa_st = ST_ACCEPT;
    logic [7:0] held [0:2];
    logic [1:0] held_n = 2'd0;
    logic       skip_cont = 1'b0;
    t_san_out   expected_out [$];
    int         bytes_stepped = 0;
    int         errors = 0;

    // traffic shaping
    bit         src_idle_en = 1'b0;
    bit         sink_idle_en = 1'b0;
    bit         sink_hold_req = 1'b0;
    int         sink_stall_left = 0;

    // one encoded character under construction
    logic [7:0] seq_buf [0:3];
    int         seq_len;

    utf8_stream_sanitizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] data_byte
        .i_s_axis_tlast  (s_tlast),   // end_of_buffer
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [7:0] out_byte
        .o_m_axis_tuser  (m_tuser),   // [0] is_replacement
        .o_m_axis_tlast  (m_tlast)    // last_of_run
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic t_btype classify(input logic [7:0] b);
        t_btype c;
        case (b[7:4])
            4'h8:       c = BT_CONT1;
            4'h9:       c = BT_CONT2;
            4'hA, 4'hB: c = BT_CONT3;
            4'hC:       c = (b[3:1] == 3'b000) ? BT_BAD : BT_LEAD2;
            4'hD:       c = BT_LEAD2;
            4'hE:       c = (b == 8'hE0) ? BT_E0 : (b == 8'hED) ? BT_ED : BT_LEAD3;
            4'hF: begin
                if (b == 8'hF0)      c = BT_F0;
                else if (b < 8'hF4)  c = BT_LEAD4;
                else if (b == 8'hF4) c = BT_F4;
                else                 c = BT_BAD;
            end
            default:    c = BT_ASCII;
        endcase
        return c;
    endfunction

    // Transition rows, one nibble per byte class, class 0 in the low nibble.
    function automatic logic [3:0] dfa_next(input logic [3:0] st, input t_btype cls);
        logic [63:0] row;
        case (st)
            4'd0:    row = 64'h1111_6411_1785_3210;
            4'd2:    row = 64'h1111_1101_0111_1101;
            4'd3:    row = 64'h1111_1121_2111_1121;
            4'd4:    row = 64'h1111_1111_2111_1111;
            4'd5:    row = 64'h1111_1121_1111_1121;
            4'd6:    row = 64'h1111_1131_3111_1111;
            4'd7:    row = 64'h1111_1131_3111_1131;
            4'd8:    row = 64'h1111_1111_1111_1131;
            default: row = 64'h1111_1111_1111_1111;
        endcase
        return row[cls*4 +: 4];
    endfunction

    // Steps the local DFA for one accepted byte and queues the bytes it releases.
    function automatic void sanitize_step(input logic [7:0] b, input logic eob);
        logic [7:0] od [0:3];
        logic       orp [0:3];
        int         n;
        logic [3:0] nxt;
        n = 0;
        if (skip_cont && (b & CONT_MASK) == CONT_TAG) begin
            // continuation swallowed by the earlier error
        end else begin
            skip_cont = 1'b0;
            bytes_stepped++;
            nxt = dfa_next(dfa_st, classify(b));
            if (nxt == ST_ACCEPT) begin
                for (int i = 0; i < 3; i++) begin
                    if (i < held_n) begin
                        od[n] = held[i];
                        orp[n] = 1'b0;
                        n++;
                    end
                end
                od[n] = b;
                orp[n] = 1'b0;
                n++;
                held_n = 2'd0;
                dfa_st = ST_ACCEPT;
            end else if (nxt == ST_REJECT) begin
                od[n] = REPL_CHAR;
                orp[n] = 1'b1;
                n++;
                held_n = 2'd0;
                dfa_st = ST_ACCEPT;
                skip_cont = 1'b1;
            end else begin
                held[held_n[0] ? 1 : (held_n[1] ? 2 : 0)] = b;
                held_n = held_n + 2'd1;
                dfa_st = nxt;
            end
        end
        if (eob) begin
            if (dfa_st != ST_ACCEPT) begin
                od[n] = REPL_CHAR;
                orp[n] = 1'b1;
                n++;
            end
            dfa_st = ST_ACCEPT;
            held_n = 2'd0;
            skip_cont = 1'b0;
        end
        for (int k = 0; k < n; k++)
            expected_out.push_back({od[k], orp[k], k == n - 1});
    endfunction

    // Sink ready: random stall bursts, or one long hold on request.
    always @(negedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_stall_left = LONG_HOLD;
        end else if (sink_stall_left == 0 && sink_idle_en && $urandom_range(0, 9) == 0) begin
            sink_stall_left = $urandom_range(1, 18);
        end
        if (sink_stall_left > 0) begin
            m_tready <= 1'b0;
            sink_stall_left = sink_stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_san_out want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected output transfer data=%h user=%b last=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.repl
                    || m_tlast !== want.last_of_run) begin
                    $display("%0t: mismatch expected data=%h user=%b last=%b, got data=%h user=%b last=%b",
                             $time, want.data, want.repl, want.last_of_run,
                             m_tdata, m_tuser, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sanitize_step(b, eob);
        @(negedge i_clk);
    endtask

    // Always moves on by at least one falling edge so valid is not driven twice at once.
    task automatic wait_for_outputs();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_out.size() != 0);
    endtask

    // Fills seq_buf with one well-formed character of random length and content.
    task automatic make_code_point();
        seq_len = $urandom_range(1, 4);
        for (int i = 1; i < 4; i++) seq_buf[i] = 8'($urandom_range(8'h80, 8'hBF));
        case (seq_len)
            1: seq_buf[0] = 8'($urandom_range(8'h00, 8'h7F));
            2: seq_buf[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: begin
                seq_buf[0] = 8'($urandom_range(8'hE0, 8'hEF));
                if (seq_buf[0] == 8'hE0)      seq_buf[1] = 8'($urandom_range(8'hA0, 8'hBF));
                else if (seq_buf[0] == 8'hED) seq_buf[1] = 8'($urandom_range(8'h80, 8'h9F));
            end
            default: begin
                seq_buf[0] = 8'($urandom_range(8'hF0, 8'hF4));
                if (seq_buf[0] == 8'hF0)      seq_buf[1] = 8'($urandom_range(8'h90, 8'hBF));
                else if (seq_buf[0] == 8'hF4) seq_buf[1] = 8'($urandom_range(8'h80, 8'h8F));
            end
        endcase
    endtask

    task automatic test_valid_sequences();
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    endtask

    // bad lead with trailing continuations, out-of-range byte, broken 3-byte sequence
    task automatic test_invalid_bytes();
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
    endtask

    task automatic test_end_of_buffer();
        send_byte(8'hE1, 1'b0); send_byte(8'h80, 1'b1);  // cut inside a sequence
        send_byte(8'hC0, 1'b1);                           // reject on the last byte
        send_byte(8'h00, 1'b1);
        send_byte(8'hF5, 1'b0); send_byte(8'h80, 1'b1);  // last byte is a skipped one
    endtask

    task automatic test_random_stream(input int count);
        int start;
        int pick;
        int pos;
        logic eob;
        start = bytes_stepped;
        while (bytes_stepped - start < count) begin
            pick = $urandom_range(0, 99);
            make_code_point();
            if (pick >= 60 && pick < 72 && seq_len > 1) begin
                seq_len = $urandom_range(1, seq_len - 1);
            end else if (pick >= 72 && pick < 84) begin
                pos = $urandom_range(0, seq_len - 1);
                seq_buf[pos] = 8'($urandom_range(0, 255));
            end else if (pick >= 84) begin
                seq_len = $urandom_range(1, 3);
                for (int i = 0; i < seq_len; i++) seq_buf[i] = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < seq_len; i++) begin
                eob = (i == seq_len - 1 && $urandom_range(0, 7) == 0)
                      || $urandom_range(0, 39) == 0;
                send_byte(seq_buf[i], eob);
            end
        end
    endtask

    // Sink holds off while long sequences keep arriving; input must back up.
    task automatic test_output_backpressure();
        src_idle_en = 1'b0;
        sink_hold_req = 1'b1;
        for (int c = 0; c < 8; c++) begin
            do make_code_point(); while (seq_len < 3);
            for (int i = 0; i < seq_len; i++) send_byte(seq_buf[i], 1'b0);
        end
    endtask

    task automatic test_sender_drain();
        src_idle_en = 1'b1;
        test_random_stream(30);
        wait_for_outputs();
        test_random_stream(30);
    endtask

    initial begin
        #5_000_000;
        $display("utf8_stream_sanitizer verification failed");
        $finish;
    end

    initial begin : main
        int guard;
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        test_valid_sequences();
        test_invalid_bytes();
        test_end_of_buffer();
        test_random_stream(220);
        test_output_backpressure();
        test_sender_drain();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random_stream(80);

        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_out.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_out.size() != 0) begin
            $display("%0t: %0d expected outputs never arrived, next expected data=%h",
                     $time, expected_out.size(), expected_out[0].data);
            errors++;
        end
        if (errors == 0)
            $display("utf8_stream_sanitizer verification clean");
        else
            $display("utf8_stream_sanitizer verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/utf8s_pkg.sv
rtl/utf8_stream_sanitizer.sv
rtl/utf8s_checker.sv
tb/tb_utf8_stream_sanitizer.sv
